// File: sv/swdg_pkg.sv
// Package for the wall density-gradient block: sizes, controller states,
// datapath command/status types and saturation helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swdg_pkg;

    localparam int DIMENSIONS = 3;

    // restoring divider: one quotient bit per cycle, 31-bit quotient
    localparam int DIV_STEPS = 31;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
    localparam logic signed [63:0] S48_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] S48_MIN = -64'sd140737488355328;
    localparam logic signed [63:0] ONE_Q16 = 64'sd65536;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RE_X, S_RE_Y, S_RE_Z,
        S_DD_X, S_DD_Y, S_DD_Z,
        S_P_X, S_P_Y, S_P_Z,
        S_DOT,
        S_ABS,
        S_DIV_INIT,
        S_DIV,
        S_FACTOR,
        S_MUL_A, S_WB_A,
        S_MUL_B, S_WB_B,
        S_MUL_C, S_WB_C,
        S_T_X, S_T_Y, S_T_Z,
        S_T_WB,
        S_FINISH
    } t_state;

    // multiplier operand selection; the tag also selects the writeback
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RE_X, MUL_RE_Y, MUL_RE_Z,
        MUL_DD_X, MUL_DD_Y, MUL_DD_Z,
        MUL_P_X, MUL_P_Y, MUL_P_Z,
        MUL_A, MUL_B, MUL_C,
        MUL_T_X, MUL_T_Y, MUL_T_Z
    } t_mul;

    typedef enum logic [2:0] {
        AUX_NONE,
        AUX_LOAD,
        AUX_ABS,
        AUX_DIV_INIT,
        AUX_DIV_STEP,
        AUX_FACTOR,
        AUX_EMIT
    } t_aux;

    typedef struct packed {
        t_aux aux;
        t_mul mul;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic last;
        logic out_stall;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] res;
        if (x > S32_MAX) begin
            res = S32_MAX[31:0];
        end else if (x < S32_MIN) begin
            res = S32_MIN[31:0];
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
        logic signed [47:0] res;
        if (x > S48_MAX) begin
            res = S48_MAX[47:0];
        end else if (x < S48_MIN) begin
            res = S48_MIN[47:0];
        end else begin
            res = x[47:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/swdg_ctrl.sv
// Controller for the wall density-gradient block: sequences the multiplier,
// divider and accumulator steps of one neighbor pair. Uses swdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swdg_ctrl
    import swdg_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '{aux: AUX_NONE, mul: MUL_NONE};
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.aux = AUX_LOAD;
                    n_state   = S_RE_X;
                end
            end
            S_RE_X: begin
                if (i_status.zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.mul = MUL_RE_X;
                    n_state   = S_RE_Y;
                end
            end
            S_RE_Y: begin o_cmd.mul = MUL_RE_Y; n_state = S_RE_Z; end
            S_RE_Z: begin o_cmd.mul = MUL_RE_Z; n_state = S_DD_X; end
            S_DD_X: begin o_cmd.mul = MUL_DD_X; n_state = S_DD_Y; end
            S_DD_Y: begin o_cmd.mul = MUL_DD_Y; n_state = S_DD_Z; end
            S_DD_Z: begin o_cmd.mul = MUL_DD_Z; n_state = S_P_X;  end
            S_P_X:  begin o_cmd.mul = MUL_P_X;  n_state = S_P_Y;  end
            S_P_Y:  begin o_cmd.mul = MUL_P_Y;  n_state = S_P_Z;  end
            S_P_Z:  begin o_cmd.mul = MUL_P_Z;  n_state = S_DOT;  end
            S_DOT:  n_state = S_ABS;
            S_ABS: begin
                o_cmd.aux = AUX_ABS;
                n_state   = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.aux = AUX_DIV_INIT;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.aux = AUX_DIV_STEP;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FACTOR;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FACTOR: begin
                o_cmd.aux = AUX_FACTOR;
                n_state   = S_MUL_A;
            end
            S_MUL_A: begin o_cmd.mul = MUL_A; n_state = S_WB_A; end
            S_WB_A:  n_state = S_MUL_B;
            S_MUL_B: begin o_cmd.mul = MUL_B; n_state = S_WB_B; end
            S_WB_B:  n_state = S_MUL_C;
            S_MUL_C: begin o_cmd.mul = MUL_C; n_state = S_WB_C; end
            S_WB_C:  n_state = S_T_X;
            S_T_X:   begin o_cmd.mul = MUL_T_X; n_state = S_T_Y; end
            S_T_Y:   begin o_cmd.mul = MUL_T_Y; n_state = S_T_Z; end
            S_T_Z:   begin o_cmd.mul = MUL_T_Z; n_state = S_T_WB; end
            S_T_WB:  n_state = S_FINISH;
            S_FINISH: begin
                if (!i_status.last) begin
                    n_state = S_IDLE;
                end else if (!i_status.out_stall) begin
                    o_cmd.aux = AUX_EMIT;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/swdg_dpath.sv
// Datapath for the wall density-gradient block: operand registers, one
// shared 32x32 multiplier, bit-serial divider, accumulators and output
// register. Uses swdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swdg_dpath
    import swdg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    input  wire logic signed [31:0] i_dist_x,
    input  wire logic signed [31:0] i_dist_y,
    input  wire logic signed [31:0] i_dist_z,
    input  wire logic        [30:0] i_rho_self,
    input  wire logic        [30:0] i_rho_wall,
    input  wire logic signed [31:0] i_kernel_slope,
    input  wire logic        [30:0] i_wall_volume,
    input  wire logic        [30:0] i_pair_distance,
    input  wire logic signed [17:0] i_dir_x,
    input  wire logic signed [17:0] i_dir_y,
    input  wire logic signed [17:0] i_dir_z,
    input  wire logic               i_last_neighbor,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_grad_x,
    output logic signed [31:0]      o_grad_y,
    output logic signed [31:0]      o_grad_z,
    output logic                    o_zero_distance_fault
);

    // captured transaction
    logic signed [31:0] r_d [3];
    logic signed [17:0] r_e [3];
    logic signed [31:0] r_diff [3];
    logic        [30:0] r_r;
    logic signed [31:0] r_rhod;
    logic signed [31:0] r_dw;
    logic        [30:0] r_vol;
    logic               r_last;
    logic               r_zero;

    // multiplier
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] r_prod;
    t_mul               r_tag;

    // dot product, squared norm, divider
    logic signed [64:0] r_dot;
    logic        [63:0] r_den;
    logic               r_neg;
    logic        [63:0] r_mag;
    logic               r_ovf;
    logic        [63:0] r_rem;
    logic        [30:0] r_num;
    logic        [30:0] r_quo;
    logic        [64:0] div_trial;
    logic               div_take;

    logic signed [31:0] r_a;
    logic signed [47:0] r_sum [3];
    logic               r_fault;
    logic               r_out_valid;

    logic signed [63:0] prod_sh;
    logic signed [63:0] q_signed;
    logic signed [63:0] q_abs;

    assign prod_sh = r_prod >>> 16;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul)
            MUL_NONE: ;
            MUL_RE_X: begin mul_a = {1'b0, r_r}; mul_b = 32'(r_e[0]); end
            MUL_RE_Y: begin mul_a = {1'b0, r_r}; mul_b = 32'(r_e[1]); end
            MUL_RE_Z: begin mul_a = {1'b0, r_r}; mul_b = 32'(r_e[2]); end
            MUL_DD_X: begin mul_a = r_d[0]; mul_b = r_d[0]; end
            MUL_DD_Y: begin mul_a = r_d[1]; mul_b = r_d[1]; end
            MUL_DD_Z: begin mul_a = r_d[2]; mul_b = r_d[2]; end
            MUL_P_X:  begin mul_a = r_d[0]; mul_b = r_diff[0]; end
            MUL_P_Y:  begin mul_a = r_d[1]; mul_b = r_diff[1]; end
            MUL_P_Z:  begin mul_a = r_d[2]; mul_b = r_diff[2]; end
            MUL_A:    begin mul_a = r_a; mul_b = r_rhod; end
            MUL_B:    begin mul_a = r_a; mul_b = r_dw; end
            MUL_C:    begin mul_a = r_a; mul_b = {1'b0, r_vol}; end
            MUL_T_X:  begin mul_a = r_a; mul_b = 32'(r_e[0]); end
            MUL_T_Y:  begin mul_a = r_a; mul_b = 32'(r_e[1]); end
            MUL_T_Z:  begin mul_a = r_a; mul_b = 32'(r_e[2]); end
            default: ;
        endcase
    end

    assign div_trial = {r_rem, r_num[30]};
    assign div_take  = (div_trial >= {1'b0, r_den});

    assign q_abs    = r_ovf ? S32_MAX : 64'($unsigned(r_quo));
    assign q_signed = r_neg ? -q_abs : q_abs;

    // input capture, multiplier and datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a * mul_b);
        r_tag  <= i_cmd.mul;

        unique case (r_tag)
            MUL_RE_X: r_diff[0] <= sat32(64'(r_d[0]) - prod_sh);
            MUL_RE_Y: r_diff[1] <= sat32(64'(r_d[1]) - prod_sh);
            MUL_RE_Z: r_diff[2] <= sat32(64'(r_d[2]) - prod_sh);
            MUL_DD_X, MUL_DD_Y, MUL_DD_Z: r_den <= r_den + r_prod;
            MUL_P_X, MUL_P_Y, MUL_P_Z:    r_dot <= r_dot + 65'(r_prod);
            MUL_A, MUL_B, MUL_C:          r_a   <= sat32(prod_sh);
            default: ;
        endcase

        unique case (i_cmd.aux)
            AUX_LOAD: begin
                r_d[0] <= i_dist_x;
                r_d[1] <= i_dist_y;
                r_d[2] <= (DIMENSIONS == 3) ? i_dist_z : '0;
                r_e[0] <= i_dir_x;
                r_e[1] <= i_dir_y;
                r_e[2] <= (DIMENSIONS == 3) ? i_dir_z : '0;
                r_r    <= i_pair_distance;
                r_rhod <= $signed({1'b0, i_rho_self}) - $signed({1'b0, i_rho_wall});
                r_dw   <= i_kernel_slope;
                r_vol  <= i_wall_volume;
                r_last <= i_last_neighbor;
                r_zero <= (i_dist_x == '0) && (i_dist_y == '0)
                          && ((DIMENSIONS == 2) || (i_dist_z == '0));
                r_den  <= '0;
                r_dot  <= '0;
            end
            AUX_ABS: begin
                r_neg <= r_dot[64];
                r_mag <= r_dot[64] ? 64'(-r_dot) : r_dot[63:0];
            end
            AUX_DIV_INIT: begin
                r_ovf <= ({15'b0, r_mag} >= {r_den, 15'b0});
                r_rem <= {15'b0, r_mag[63:15]};
                r_num <= {r_mag[14:0], 16'b0};
                r_quo <= '0;
            end
            AUX_DIV_STEP: begin
                r_rem <= div_take ? 64'(div_trial - {1'b0, r_den}) : div_trial[63:0];
                r_num <= {r_num[29:0], 1'b0};
                r_quo <= {r_quo[29:0], div_take};
            end
            AUX_FACTOR: r_a <= sat32(ONE_Q16 - q_signed);
            default: ;
        endcase
    end

    // accumulator, fault flag and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_sum[2]    <= '0;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.aux == AUX_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_tag)
                MUL_T_X: r_sum[0] <= sat48(64'(r_sum[0]) - prod_sh);
                MUL_T_Y: r_sum[1] <= sat48(64'(r_sum[1]) - prod_sh);
                MUL_T_Z: r_sum[2] <= sat48(64'(r_sum[2]) - prod_sh);
                default: ;
            endcase
            unique case (i_cmd.aux)
                AUX_LOAD: begin
                    if ((i_dist_x == '0) && (i_dist_y == '0)
                        && ((DIMENSIONS == 2) || (i_dist_z == '0))) begin
                        r_fault <= 1'b1;
                    end
                end
                AUX_EMIT: begin
                    r_sum[0]    <= '0;
                    r_sum[1]    <= '0;
                    r_sum[2]    <= '0;
                    r_fault     <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.aux == AUX_EMIT) begin
            o_grad_x              <= sat32(64'(r_sum[0]));
            o_grad_y              <= sat32(64'(r_sum[1]));
            o_grad_z              <= (DIMENSIONS == 3) ? sat32(64'(r_sum[2])) : '0;
            o_zero_distance_fault <= r_fault;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status.zero      = r_zero;
    assign o_status.last      = r_last;
    assign o_status.out_stall = r_out_valid && !i_out_ready;

endmodule

`default_nettype wire

// File: sv/sph_wall_density_gradient.sv
// Top level of the wall density-gradient accumulator: controller and
// datapath. Depends on swdg_pkg, swdg_ctrl and swdg_dpath.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   input    | i_in_valid / o_in_ready   | i_dist_*, i_rho_*, i_kernel_slope,
//            |                           | i_wall_volume, i_pair_distance,
//            |                           | i_dir_*, i_last_neighbor
//   output   | o_out_valid / i_out_ready | o_grad_*, o_zero_distance_fault
//
// The time from acceptance of one neighbor pair to the next ready is set by
// the single shared 32x32 multiplier (15 products) and the 31-step divider.
// A pair with zero wall distance skips the multiplier and divider steps.
// A result waits in the output register while the next pair is accepted; the
// controller holds only if a new result is due and that register is still full.
// Reset clears the accumulators, the fault flag and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module sph_wall_density_gradient
    import swdg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [31:0] i_dist_x,
    input  wire logic signed [31:0] i_dist_y,
    input  wire logic signed [31:0] i_dist_z,
    input  wire logic        [30:0] i_rho_self,
    input  wire logic        [30:0] i_rho_wall,
    input  wire logic signed [31:0] i_kernel_slope,
    input  wire logic        [30:0] i_wall_volume,
    input  wire logic        [30:0] i_pair_distance,
    input  wire logic signed [17:0] i_dir_x,
    input  wire logic signed [17:0] i_dir_y,
    input  wire logic signed [17:0] i_dir_z,
    input  wire logic               i_last_neighbor,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_grad_x,
    output logic signed [31:0]      o_grad_y,
    output logic signed [31:0]      o_grad_z,
    output logic                    o_zero_distance_fault
);

    t_cmd    cmd;
    t_status status;

    swdg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    swdg_dpath u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_status              (status),
        .i_dist_x              (i_dist_x),
        .i_dist_y              (i_dist_y),
        .i_dist_z              (i_dist_z),
        .i_rho_self            (i_rho_self),
        .i_rho_wall            (i_rho_wall),
        .i_kernel_slope        (i_kernel_slope),
        .i_wall_volume         (i_wall_volume),
        .i_pair_distance       (i_pair_distance),
        .i_dir_x               (i_dir_x),
        .i_dir_y               (i_dir_y),
        .i_dir_z               (i_dir_z),
        .i_last_neighbor       (i_last_neighbor),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_grad_x              (o_grad_x),
        .o_grad_y              (o_grad_y),
        .o_grad_z              (o_grad_z),
        .o_zero_distance_fault (o_zero_distance_fault)
    );

endmodule

`default_nettype wire

// File: tb/swdg_grad_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the wall density-gradient block: predicts the gradient of each
// particle from accepted pair transactions and checks every emitted transaction.
// Depends on swdg_pkg (DIMENSIONS).
module swdg_grad_checker
    import swdg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [31:0] i_dist_x,
    input  logic signed [31:0] i_dist_y,
    input  logic signed [31:0] i_dist_z,
    input  logic        [30:0] i_rho_self,
    input  logic        [30:0] i_rho_wall,
    input  logic signed [31:0] i_kernel_slope,
    input  logic        [30:0] i_wall_volume,
    input  logic        [30:0] i_pair_distance,
    input  logic signed [17:0] i_dir_x,
    input  logic signed [17:0] i_dir_y,
    input  logic signed [17:0] i_dir_z,
    input  logic               i_last_neighbor,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_grad_x,
    input  logic signed [31:0] i_grad_y,
    input  logic signed [31:0] i_grad_z,
    input  logic               i_zero_distance_fault,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam logic signed [63:0] LIM32_HI = 64'sd2147483647;
    localparam logic signed [63:0] LIM32_LO = -64'sd2147483648;
    localparam logic signed [63:0] LIM48_HI = 64'sd140737488355327;
    localparam logic signed [63:0] LIM48_LO = -64'sd140737488355328;
    localparam logic signed [63:0] UNIT_Q16 = 64'sd65536;
    localparam int                 MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gz;
        logic               fault;
    } t_grad;

    t_grad              grads_due[$];
    logic signed [63:0] acc_x, acc_y, acc_z;
    logic               fault_acc;

    function automatic logic signed [63:0] clamp(input logic signed [63:0] x,
                                                 input logic signed [63:0] lo,
                                                 input logic signed [63:0] hi);
        if (x < lo) begin
            return lo;
        end else if (x > hi) begin
            return hi;
        end
        return x;
    endfunction

    // Q16.16 product, floor rounding, saturated to 32 bits
    function automatic logic signed [63:0] mul_q16(input logic signed [63:0] x,
                                                   input logic signed [63:0] y);
        logic signed [63:0] prod;
        prod = x * y;
        return clamp(prod >>> 16, LIM32_LO, LIM32_HI);
    endfunction

    task automatic absorb_pair();
        logic signed [63:0] dv [3];
        logic signed [63:0] ev [3];
        logic signed [63:0] term [3];
        logic signed [63:0] rr, diff, prod, q, fac, a;
        logic        [63:0] pos, neg, den, mag;
        logic       [127:0] num, quo;
        logic               zero, negq;
        t_grad              res;

        dv[0] = 64'(i_dist_x);
        dv[1] = 64'(i_dist_y);
        dv[2] = 64'(i_dist_z);
        ev[0] = 64'(i_dir_x);
        ev[1] = 64'(i_dir_y);
        ev[2] = 64'(i_dir_z);
        if (DIMENSIONS == 2) begin
            dv[2] = 0;
            ev[2] = 0;
        end
        rr = {33'd0, i_pair_distance};

        pos = 0;
        neg = 0;
        den = 0;
        zero = 1'b1;
        for (int k = 0; k < 3; k++) begin
            diff = clamp(dv[k] - ((rr * ev[k]) >>> 16), LIM32_LO, LIM32_HI);
            prod = dv[k] * diff;
            if (dv[k] != 0) zero = 1'b0;
            if (prod >= 0) pos += prod;
            else neg += -prod;
            den += dv[k] * dv[k];
        end

        if (zero) begin
            fault_acc = 1'b1;
        end else begin
            negq = neg > pos;
            mag = negq ? neg - pos : pos - neg;
            num = {48'd0, mag, 16'd0};
            quo = num / {64'd0, den};
            q = (quo > 128'd2147483647) ? LIM32_HI : $signed(quo[63:0]);
            if (negq) fac = clamp(UNIT_Q16 + q, LIM32_LO, LIM32_HI);
            else fac = clamp(UNIT_Q16 - q, LIM32_LO, LIM32_HI);
            a = mul_q16(fac, $signed({33'd0, i_rho_self}) - $signed({33'd0, i_rho_wall}));
            a = mul_q16(a, 64'(i_kernel_slope));
            a = mul_q16(a, $signed({33'd0, i_wall_volume}));
            for (int k = 0; k < 3; k++) begin
                term[k] = (a * ev[k]) >>> 16;
            end
            acc_x = clamp(acc_x - term[0], LIM48_LO, LIM48_HI);
            acc_y = clamp(acc_y - term[1], LIM48_LO, LIM48_HI);
            acc_z = clamp(acc_z - term[2], LIM48_LO, LIM48_HI);
        end

        if (i_last_neighbor) begin
            res.gx = 32'(clamp(acc_x, LIM32_LO, LIM32_HI));
            res.gy = 32'(clamp(acc_y, LIM32_LO, LIM32_HI));
            res.gz = (DIMENSIONS == 2) ? 32'sd0 : 32'(clamp(acc_z, LIM32_LO, LIM32_HI));
            res.fault = fault_acc;
            grads_due.insert(grads_due.size(), res);
            acc_x = 0;
            acc_y = 0;
            acc_z = 0;
            fault_acc = 1'b0;
        end
    endtask

    task automatic flag_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_grad();
        t_grad want;
        if (grads_due.size() == 0) begin
            flag_mismatch($sformatf("gradient transaction with none pending (%0d %0d %0d %0b)",
                                    i_grad_x, i_grad_y, i_grad_z, i_zero_distance_fault));
        end else begin
            want = grads_due.pop_front();
            if (i_grad_x !== want.gx)
                flag_mismatch($sformatf("grad_x expected %0d got %0d", want.gx, i_grad_x));
            if (i_grad_y !== want.gy)
                flag_mismatch($sformatf("grad_y expected %0d got %0d", want.gy, i_grad_y));
            if (i_grad_z !== want.gz)
                flag_mismatch($sformatf("grad_z expected %0d got %0d", want.gz, i_grad_z));
            if (i_zero_distance_fault !== want.fault)
                flag_mismatch($sformatf("zero_distance_fault expected %0b got %0b",
                                        want.fault, i_zero_distance_fault));
        end
    endtask

    // output side first: a result leaving now never belongs to a pair arriving now
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            acc_x = 0;
            acc_y = 0;
            acc_z = 0;
            fault_acc = 1'b0;
            grads_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) check_grad();
            if (i_in_valid && i_in_ready) absorb_pair();
        end
        o_pending = grads_due.size();
    end

endmodule

// File: tb/tb_sph_wall_density_gradient.sv
`timescale 1ns / 1ps
// Testbench top for sph_wall_density_gradient: clock, reset, pair stimulus with
// bursty sending and receiver back-pressure, and the verdict.
// Depends on swdg_pkg, sph_wall_density_gradient and swdg_grad_checker.
module tb_sph_wall_density_gradient;
    import swdg_pkg::*;

    localparam int RANDOM_PAIRS     = 735;
    localparam int HOLD_OFF_AT      = 200;
    localparam int DRAIN_AT         = 450;
    localparam int HOLD_OFF_CYCLES  = 1500;
    localparam int SETTLE_CYCLES    = 120;
    localparam int RUN_LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic        [30:0] rs;
        logic        [30:0] rw;
        logic signed [31:0] slope;
        logic        [30:0] vol;
        logic        [30:0] r;
        logic signed [17:0] ex;
        logic signed [17:0] ey;
        logic signed [17:0] ez;
        logic               last;
    } t_wall_pair;

    typedef enum logic [1:0] {
        GEN_PHYS,
        GEN_FULL,
        GEN_EDGE,
        GEN_ZERO_DIST
    } t_gen;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [31:0] i_dist_x, i_dist_y, i_dist_z;
    logic        [30:0] i_rho_self, i_rho_wall;
    logic signed [31:0] i_kernel_slope;
    logic        [30:0] i_wall_volume, i_pair_distance;
    logic signed [17:0] i_dir_x, i_dir_y, i_dir_z;
    logic               i_last_neighbor;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_grad_x, o_grad_y, o_grad_z;
    logic               o_zero_distance_fault;

    int   fail_count;
    int   grads_pending;
    int   burst_left;
    int   cycle_count;
    logic hold_off_req;
    logic hold_off_done;

    sph_wall_density_gradient dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_dist_x              (i_dist_x),
        .i_dist_y              (i_dist_y),
        .i_dist_z              (i_dist_z),
        .i_rho_self            (i_rho_self),
        .i_rho_wall            (i_rho_wall),
        .i_kernel_slope        (i_kernel_slope),
        .i_wall_volume         (i_wall_volume),
        .i_pair_distance       (i_pair_distance),
        .i_dir_x               (i_dir_x),
        .i_dir_y               (i_dir_y),
        .i_dir_z               (i_dir_z),
        .i_last_neighbor       (i_last_neighbor),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_grad_x              (o_grad_x),
        .o_grad_y              (o_grad_y),
        .o_grad_z              (o_grad_z),
        .o_zero_distance_fault (o_zero_distance_fault)
    );

    swdg_grad_checker u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .i_in_ready            (o_in_ready),
        .i_dist_x              (i_dist_x),
        .i_dist_y              (i_dist_y),
        .i_dist_z              (i_dist_z),
        .i_rho_self            (i_rho_self),
        .i_rho_wall            (i_rho_wall),
        .i_kernel_slope        (i_kernel_slope),
        .i_wall_volume         (i_wall_volume),
        .i_pair_distance       (i_pair_distance),
        .i_dir_x               (i_dir_x),
        .i_dir_y               (i_dir_y),
        .i_dir_z               (i_dir_z),
        .i_last_neighbor       (i_last_neighbor),
        .i_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .i_grad_x              (o_grad_x),
        .i_grad_y              (o_grad_y),
        .i_grad_z              (o_grad_z),
        .i_zero_distance_fault (o_zero_distance_fault),
        .o_fail_count          (fail_count),
        .o_pending             (grads_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic t_wall_pair pair_of(input logic signed [31:0] dx, dy, dz,
                                           input logic [30:0] rs, rw,
                                           input logic signed [31:0] slope,
                                           input logic [30:0] vol, r,
                                           input logic signed [17:0] ex, ey, ez,
                                           input logic last);
        t_wall_pair p;
        p.dx = dx;
        p.dy = dy;
        p.dz = dz;
        p.rs = rs;
        p.rw = rw;
        p.slope = slope;
        p.vol = vol;
        p.r = r;
        p.ex = ex;
        p.ey = ey;
        p.ez = ez;
        p.last = last;
        return p;
    endfunction

    function automatic logic signed [31:0] edge_s32();
        logic signed [31:0] v;
        case ($urandom_range(0, 4))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7FFF_FFFF;
            2: v = 32'sd0;
            3: v = 32'sd1;
            default: v = -32'sd1;
        endcase
        return v;
    endfunction

    function automatic logic [30:0] edge_u31();
        logic [30:0] v;
        case ($urandom_range(0, 3))
            0: v = 31'd0;
            1: v = 31'h7FFF_FFFF;
            2: v = 31'd1;
            default: v = 31'd65536;
        endcase
        return v;
    endfunction

    function automatic logic signed [17:0] edge_s18();
        logic signed [17:0] v;
        case ($urandom_range(0, 4))
            0: v = -18'sd131072;
            1: v = 18'sd131071;
            2: v = 18'sd0;
            3: v = 18'sd65536;
            default: v = -18'sd65536;
        endcase
        return v;
    endfunction

    function automatic t_wall_pair random_pair(input t_gen g);
        t_wall_pair p;
        case (g)
            GEN_FULL: begin
                p.dx = $urandom;
                p.dy = $urandom;
                p.dz = $urandom;
                p.rs = 31'($urandom);
                p.rw = 31'($urandom);
                p.slope = $urandom;
                p.vol = 31'($urandom);
                p.r = 31'($urandom);
                p.ex = 18'($urandom);
                p.ey = 18'($urandom);
                p.ez = 18'($urandom);
            end
            GEN_EDGE: begin
                p.dx = edge_s32();
                p.dy = edge_s32();
                p.dz = edge_s32();
                p.rs = edge_u31();
                p.rw = edge_u31();
                p.slope = edge_s32();
                p.vol = edge_u31();
                p.r = edge_u31();
                p.ex = edge_s18();
                p.ey = edge_s18();
                p.ez = edge_s18();
            end
            default: begin
                // plausible geometry: distances within a few units, unit-ish directions
                p.dx = int'($urandom_range(0, 524288)) - 262144;
                p.dy = int'($urandom_range(0, 524288)) - 262144;
                p.dz = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 524288)) - 262144;
                p.rs = 31'($urandom_range(49152, 98304));
                p.rw = 31'($urandom_range(49152, 98304));
                p.slope = int'($urandom_range(0, 2097152)) - 1048576;
                p.vol = 31'($urandom_range(0, 65536));
                p.r = 31'($urandom_range(0, 262144));
                p.ex = 18'(int'($urandom_range(0, 131072)) - 65536);
                p.ey = 18'(int'($urandom_range(0, 131072)) - 65536);
                p.ez = 18'(int'($urandom_range(0, 131072)) - 65536);
                if (g == GEN_ZERO_DIST) begin
                    p.dx = 0;
                    p.dy = 0;
                    p.dz = 0;
                end
            end
        endcase
        p.last = 1'b0;
        return p;
    endfunction

    // offer one pair transaction, inserting a random gap between bursts
    task automatic offer_pair(input t_wall_pair p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
            burst_left = $urandom_range(1, 15);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_dist_x = p.dx;
        i_dist_y = p.dy;
        i_dist_z = p.dz;
        i_rho_self = p.rs;
        i_rho_wall = p.rw;
        i_kernel_slope = p.slope;
        i_wall_volume = p.vol;
        i_pair_distance = p.r;
        i_dir_x = p.ex;
        i_dir_y = p.ey;
        i_dir_z = p.ez;
        i_last_neighbor = p.last;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (grads_pending != 0) @(negedge i_clk);
    endtask

    // receiver: segments of varying ready density, plus one long hold-off
    initial begin
        int seg_len;
        int pct;
        i_out_ready = 1'b0;
        hold_off_done = 1'b0;
        wait (i_rst_n);
        forever begin
            seg_len = $urandom_range(20, 300);
            case ($urandom_range(0, 3))
                0: pct = 100;
                1: pct = 80;
                2: pct = 50;
                default: pct = 15;
            endcase
            repeat (seg_len) begin
                @(negedge i_clk);
                if (hold_off_req && !hold_off_done) begin
                    i_out_ready = 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                    hold_off_done = 1'b1;
                end
                i_out_ready = ($urandom_range(0, 99) < pct);
            end
        end
    end

    initial begin
        int         sent;
        int         grp;
        int         roll;
        logic       drained;
        t_gen       g;
        t_wall_pair p;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_dist_x = 0;
        i_dist_y = 0;
        i_dist_z = 0;
        i_rho_self = 0;
        i_rho_wall = 0;
        i_kernel_slope = 0;
        i_wall_volume = 0;
        i_pair_distance = 0;
        i_dir_x = 0;
        i_dir_y = 0;
        i_dir_z = 0;
        i_last_neighbor = 1'b0;
        hold_off_req = 1'b0;
        burst_left = 0;
        drained = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // basic pair
        offer_pair(pair_of(65536, 0, 0, 98304, 65536, -65536, 65536, 32768,
                           65536, 0, 0, 1'b1));
        // zero wall distance alone, then zero distance followed by a normal pair
        offer_pair(pair_of(0, 0, 0, 98304, 65536, 65536, 65536, 65536, 0, 65536, 0, 1'b1));
        offer_pair(pair_of(0, 0, 0, 98304, 65536, 65536, 65536, 65536, 0, 65536, 0, 1'b0));
        offer_pair(pair_of(32768, -65536, 16384, 131072, 65536, 65536, 32768, 49152,
                           46341, -46341, 0, 1'b1));
        // field extremes
        offer_pair(pair_of(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 0,
                           32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                           18'sd131071, 18'sd131071, 18'sd131071, 1'b1));
        offer_pair(pair_of(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 31'h7FFF_FFFF,
                           32'sh8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                           -18'sd131072, -18'sd131072, -18'sd131072, 1'b1));
        // direction outside the unit range
        offer_pair(pair_of(98304, 65536, -32768, 80000, 70000, -300000, 50000, 120000,
                           18'sd131071, -18'sd131072, 18'sd100000, 1'b1));
        // ratio capped, both signs
        offer_pair(pair_of(1, 0, 0, 98304, 65536, 65536, 65536, 31'h4000_0000,
                           65536, 0, 0, 1'b1));
        offer_pair(pair_of(1, 0, 0, 98304, 65536, 65536, 65536, 31'h4000_0000,
                           -65536, 0, 0, 1'b1));
        // equal densities, then wall denser than the particle
        offer_pair(pair_of(65536, 65536, 0, 70000, 70000, 65536, 65536, 65536,
                           46341, 46341, 0, 1'b1));
        offer_pair(pair_of(-65536, 32768, 0, 60000, 90000, -200000, 40000, 30000,
                           -65536, 0, 0, 1'b1));
        // only z nonzero
        offer_pair(pair_of(0, 0, 65536, 98304, 65536, 65536, 65536, 16384, 0, 0, 65536, 1'b1));
        // several neighbors accumulating, zero slope and zero volume among them
        offer_pair(pair_of(65536, 0, 0, 98304, 65536, 0, 65536, 32768, 65536, 0, 0, 1'b0));
        offer_pair(pair_of(65536, 0, 0, 98304, 65536, 65536, 0, 32768, 65536, 0, 0, 1'b0));
        offer_pair(pair_of(-131072, 65536, 65536, 200000, 65536, 800000, 65536, 100000,
                           -37837, 37837, 37837, 1'b0));
        offer_pair(pair_of(-131072, 65536, 65536, 200000, 65536, 800000, 65536, 100000,
                           -37837, 37837, 37837, 1'b1));

        sent = 0;
        while (sent < RANDOM_PAIRS) begin
            grp = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
            for (int j = 0; j < grp; j++) begin
                roll = $urandom_range(0, 99);
                if (roll < 60) g = GEN_PHYS;
                else if (roll < 80) g = GEN_FULL;
                else if (roll < 93) g = GEN_EDGE;
                else g = GEN_ZERO_DIST;
                p = random_pair(g);
                p.last = (j == grp - 1);
                offer_pair(p);
                sent++;
            end
            if (sent >= HOLD_OFF_AT) hold_off_req = 1'b1;
            if (sent >= DRAIN_AT && !drained) begin
                wait_for_results();
                drained = 1'b1;
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
sv/swdg_pkg.sv
sv/swdg_ctrl.sv
sv/swdg_dpath.sv
sv/sph_wall_density_gradient.sv
tb/swdg_grad_checker.sv
tb/tb_sph_wall_density_gradient.sv
